[rtl/core/adw_pkg.sv]
`timescale 1ns / 1ps

package adw_pkg;

    // Sample format and table size.
    localparam int SAMPLE_WIDTH    = 16;
    localparam int EXP_TABLE_DEPTH = 256;

    // Configuration register widths and the APB port.
    localparam int GAIN_W   = 18;
    localparam int THRESH_W = 16;
    localparam int MODE_W   = 3;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 4;

    localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(256);
    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(16384);

    // Working format: 23 fraction bits.
    localparam int    WFRAC   = 23;
    localparam int    SFRAC   = SAMPLE_WIDTH - 1;
    localparam longint ONE_W_L = 64'sd1 <<< WFRAC;

    // Gain product and its alignment to the working format.
    localparam int P_W      = SAMPLE_WIDTH + GAIN_W + 1;
    localparam int GAIN_SH  = (SFRAC + 8 >= WFRAC) ? (SFRAC + 8 - WFRAC) : 0;
    localparam int GAIN_LSH = (SFRAC + 8 < WFRAC) ? (WFRAC - SFRAC - 8) : 0;
    localparam int GAIN_RND = (2 ** GAIN_SH) / 2;
    localparam int W_W      = P_W + GAIN_LSH;

    // Shaped value, clamped to +-2.0.
    localparam int Y_W = WFRAC + 3;

    // Exponential shaper.
    localparam int A_W   = WFRAC + 5;
    localparam int ETF   = 27;
    localparam int POS_W = A_W + $clog2(EXP_TABLE_DEPTH + 1);
    localparam int K_W   = POS_W - ETF;
    localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
    localparam int TAB_W = 32;
    localparam int EP_W  = TAB_W + ETF;

    // Quadratic soft clip: square, then divide by 3 through a reciprocal.
    localparam int D_W       = WFRAC;
    localparam int SQ_W      = 2 * D_W;
    localparam int U_W       = SQ_W + 1 - WFRAC;
    localparam int QP_W      = 2 * U_W;
    localparam int RECIP3_SH = U_W + 1;
    localparam logic [U_W-1:0] RECIP3 = U_W'(((64'd1 << RECIP3_SH) + 64'd2) / 64'd3);

    // Output alignment.
    localparam int OUT_SH  = (SFRAC <= WFRAC) ? (WFRAC - SFRAC) : 0;
    localparam int OUT_LSH = (SFRAC > WFRAC) ? (SFRAC - WFRAC) : 0;
    localparam int OUT_RND = (2 ** OUT_SH) / 2;
    localparam int R_W     = Y_W + 1 + OUT_LSH;

    typedef enum logic [MODE_W-1:0] {
        MODE_HARD = 3'd0,
        MODE_POLY = 3'd1,
        MODE_EXP  = 3'd2,
        MODE_HALF = 3'd3,
        MODE_FULL = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        REG_GAIN   = 2'd0,
        REG_THRESH = 2'd1,
        REG_MODE   = 2'd2
    } t_reg_idx;

    // Which path supplies the final shaped value.
    typedef enum logic [1:0] {
        YSRC_DIRECT   = 2'd0,
        YSRC_POLY_POS = 2'd1,
        YSRC_POLY_NEG = 2'd2,
        YSRC_EXP      = 2'd3
    } t_ysrc;

    typedef logic [EXP_TABLE_DEPTH:0][TAB_W-1:0]   t_exp_full;
    typedef logic [EXP_TABLE_DEPTH-1:0][TAB_W-1:0] t_exp_tab;

    // exp(-16k/DEPTH) in Q31 for k = 0..DEPTH, from a series for one step
    // and repeated rounded multiplication.
    function automatic t_exp_full exp_build();
        t_exp_full   tab;
        logic [63:0] h;
        logic [63:0] term;
        logic [63:0] psum;
        logic [63:0] nsum;
        logic [63:0] ratio;
        logic [63:0] prev;
        h    = (64'd16 << 31) / EXP_TABLE_DEPTH;
        term = 64'd1 << 31;
        psum = term;
        nsum = 64'd0;
        for (int n = 1; n < 24; n++) begin
            term = ((term * h) >> 31) / 64'(n);
            if (n % 2 == 1) begin
                nsum = nsum + term;
            end else begin
                psum = psum + term;
            end
        end
        ratio  = (psum > nsum) ? (psum - nsum) : 64'd0;
        prev   = 64'd1 << 31;
        tab[0] = TAB_W'(prev);
        for (int k = 1; k <= EXP_TABLE_DEPTH; k++) begin
            prev   = (prev * ratio + (64'd1 << 30)) >> 31;
            tab[k] = TAB_W'(prev);
        end
        return tab;
    endfunction

    function automatic t_exp_tab exp_base_tab();
        t_exp_full full;
        t_exp_tab  tab;
        full = exp_build();
        for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
            tab[k] = full[k];
        end
        return tab;
    endfunction

    function automatic t_exp_tab exp_diff_tab();
        t_exp_full full;
        t_exp_tab  tab;
        full = exp_build();
        for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
            tab[k] = full[k] - full[k+1];
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_BASE = exp_base_tab();
    localparam t_exp_tab EXP_DIFF = exp_diff_tab();

endpackage

[rtl/core/adw_in_if.sv]
`timescale 1ns / 1ps

interface adw_in_if
    import adw_pkg::*;
();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           frame_end;

    modport source (output valid, sample, frame_end, input ready);
    modport sink   (input valid, sample, frame_end, output ready);
endinterface

[rtl/core/adw_out_if.sv]
`timescale 1ns / 1ps

interface adw_out_if
    import adw_pkg::*;
();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] left;
    logic signed [SAMPLE_WIDTH-1:0] right;
    logic                           frame_last;

    modport source (output valid, left, right, frame_last, input ready);
    modport sink   (input valid, left, right, frame_last, output ready);
endinterface

[rtl/core/audio_distortion_waveshaper_top.sv]
// Throughput: one sample per clock while the output is ready, over five register stages,
// each with its own valid bit; a stage loads whenever it is empty or the next one loads,
// so bubbles close up. Gain, squaring and interpolation, and the divide-by-three multiply
// sit in separate stages. Synchronous active-low reset clears all valid bits, holds the
// input not ready, and loads gain 1.0, threshold 0.5 and full-wave mode; the exponential
// table is constant logic.
`timescale 1ns / 1ps

module audio_distortion_waveshaper_top
    import adw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    adw_in_if.sink             i_smp,
    adw_out_if.source          o_smp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    localparam int W1 = W_W + 1;
    localparam int W2 = W_W + 2;

    localparam logic signed [W2-1:0]  C3_ONE  = W2'(ONE_W_L);
    localparam logic signed [W2-1:0]  C3_TWO  = W2'(2 * ONE_W_L);
    localparam logic signed [W1-1:0]  C_CLAMP = W1'(2 * ONE_W_L);
    localparam logic signed [W1-1:0]  C_EXPLIM = W1'(16 * ONE_W_L);
    localparam logic signed [Y_W-1:0] Y_ONE   = Y_W'(ONE_W_L);
    localparam logic [TAB_W:0]        ONE_T   = (TAB_W+1)'(64'd1 << 31);
    localparam logic signed [R_W-1:0] OMAX    = R_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [R_W-1:0] OMIN    = R_W'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));

    // Configuration registers.
    logic [GAIN_W-1:0]   r_gain;
    logic [THRESH_W-1:0] r_thresh;
    logic [MODE_W-1:0]   r_mode;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_RESET;
            r_thresh <= THRESH_RESET;
            r_mode   <= MODE_FULL;
        end else if (psel && penable && pwrite) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_GAIN:   r_gain   <= pwdata[GAIN_W-1:0];
                REG_THRESH: r_thresh <= pwdata[THRESH_W-1:0];
                REG_MODE:   r_mode   <= pwdata[MODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_GAIN:   prdata = APB_DW'(r_gain);
            REG_THRESH: prdata = APB_DW'(r_thresh);
            REG_MODE:   prdata = APB_DW'(r_mode);
            default:    prdata = '0;
        endcase
    end

    // Stage enables: a stage loads when it is empty or the next one loads.
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic en1, en2, en3, en4, en5;

    assign en5 = !r_v5 || o_smp.ready;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign i_smp.ready = en1 && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_smp.valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    // ---------------- Stage 1: gain ----------------
    logic signed [P_W-1:0] n_prod;
    logic signed [W_W-1:0] n_w;
    logic signed [W_W-1:0] r_s1_w;
    logic                  r_s1_last;

    always_comb begin
        n_prod = i_smp.sample * signed'({1'b0, r_gain});
        n_w    = ((W_W'(n_prod) + W_W'(GAIN_RND)) >>> GAIN_SH) <<< GAIN_LSH;
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_smp.valid) begin
            r_s1_w    <= n_w;
            r_s1_last <= i_smp.frame_end;
        end
    end

    // ---------------- Stage 2: shaper selection and table lookup ----------------
    logic signed [W1-1:0]  n_wx;
    logic signed [W1-1:0]  n_abs;
    logic signed [W2-1:0]  n_x3;
    logic signed [W1-1:0]  n_thr;
    logic signed [W1-1:0]  n_yfull;
    logic signed [Y_W-1:0] n_ysimple;
    logic [D_W-1:0]        n_d;
    t_ysrc                 n_ysrc;
    logic [A_W-1:0]        n_a;
    logic [POS_W-1:0]      n_pos;
    logic [K_W-1:0]        n_k;
    logic                  n_sat;
    logic [IDX_W-1:0]      n_idx;
    logic signed [W2-1:0]  n_dfull;

    logic signed [Y_W-1:0] r_s2_ysimple;
    logic [D_W-1:0]        r_s2_d;
    t_ysrc                 r_s2_ysrc;
    logic                  r_s2_neg;
    logic                  r_s2_sat;
    logic [TAB_W-1:0]      r_s2_e0;
    logic [TAB_W-1:0]      r_s2_diff;
    logic [ETF-1:0]        r_s2_frac;
    logic                  r_s2_last;

    always_comb begin
        n_wx    = W1'(r_s1_w);
        n_abs   = (r_s1_w < 0) ? -n_wx : n_wx;
        n_x3    = (W2'(r_s1_w) <<< 1) + W2'(r_s1_w);
        n_thr   = signed'(W1'({r_thresh, 8'b0}));
        n_yfull = n_wx;
        n_dfull = '0;
        n_ysrc  = YSRC_DIRECT;

        unique case (t_mode'(r_mode))
            MODE_HARD: begin
                if (n_wx > n_thr) begin
                    n_yfull = n_thr;
                end else if (n_wx < -n_thr) begin
                    n_yfull = -n_thr;
                end
            end
            MODE_POLY: begin
                if (n_x3 > C3_TWO) begin
                    n_yfull = W1'(ONE_W_L);
                end else if (n_x3 > C3_ONE) begin
                    n_ysrc  = YSRC_POLY_POS;
                    n_dfull = C3_TWO - n_x3;
                end else if (n_x3 < -C3_TWO) begin
                    n_yfull = W1'(-ONE_W_L);
                end else if (n_x3 < -C3_ONE) begin
                    n_ysrc  = YSRC_POLY_NEG;
                    n_dfull = C3_TWO + n_x3;
                end else begin
                    n_yfull = n_wx <<< 1;
                end
            end
            MODE_EXP:  n_ysrc  = YSRC_EXP;
            MODE_HALF: n_yfull = (r_s1_w > 0) ? n_wx : '0;
            MODE_FULL: n_yfull = n_abs;
            default:   n_yfull = n_wx;
        endcase

        // Values beyond +-2.0 are clamped here; saturation to the output sample range follows in stage 5.
        if (n_yfull > C_CLAMP) begin
            n_ysimple = Y_W'(C_CLAMP);
        end else if (n_yfull < -C_CLAMP) begin
            n_ysimple = Y_W'(-C_CLAMP);
        end else begin
            n_ysimple = n_yfull[Y_W-1:0];
        end
        n_d = n_dfull[D_W-1:0];

        // Exponential path: magnitude limited to 16.0, then split into index and fraction.
        n_a   = (n_abs > C_EXPLIM) ? A_W'(C_EXPLIM) : n_abs[A_W-1:0];
        n_pos = POS_W'(n_a) * POS_W'(EXP_TABLE_DEPTH);
        n_k   = n_pos[POS_W-1:ETF];
        n_sat = (n_k >= K_W'(EXP_TABLE_DEPTH));
        n_idx = n_sat ? '0 : n_k[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r_v1) begin
            r_s2_ysimple <= n_ysimple;
            r_s2_d       <= n_d;
            r_s2_ysrc    <= n_ysrc;
            r_s2_neg     <= (r_s1_w < 0);
            r_s2_sat     <= n_sat;
            r_s2_e0      <= EXP_BASE[n_idx];
            r_s2_diff    <= EXP_DIFF[n_idx];
            r_s2_frac    <= n_pos[ETF-1:0];
            r_s2_last    <= r_s1_last;
        end
    end

    // ---------------- Stage 3: square and interpolation products ----------------
    logic [SQ_W-1:0]       r_s3_sq;
    logic [EP_W-1:0]       r_s3_ep;
    logic signed [Y_W-1:0] r_s3_ysimple;
    t_ysrc                 r_s3_ysrc;
    logic                  r_s3_neg;
    logic                  r_s3_sat;
    logic [TAB_W-1:0]      r_s3_e0;
    logic                  r_s3_last;

    always_ff @(posedge i_clk) begin
        if (en3 && r_v2) begin
            r_s3_sq      <= SQ_W'(r_s2_d) * SQ_W'(r_s2_d);
            r_s3_ep      <= EP_W'(r_s2_diff) * EP_W'(r_s2_frac);
            r_s3_ysimple <= r_s2_ysimple;
            r_s3_ysrc    <= r_s2_ysrc;
            r_s3_neg     <= r_s2_neg;
            r_s3_sat     <= r_s2_sat;
            r_s3_e0      <= r_s2_e0;
            r_s3_last    <= r_s2_last;
        end
    end

    // ---------------- Stage 4: divide by three, finish exponential ----------------
    logic [SQ_W:0]         n_sqr;
    logic [U_W-1:0]        n_u;
    logic [TAB_W-1:0]      n_e;
    logic [TAB_W:0]        n_emag;
    logic [Y_W-1:0]        n_mag;
    logic signed [Y_W-1:0] n_yexp;

    logic [QP_W-1:0]       r_s4_qp;
    logic signed [Y_W-1:0] r_s4_yexp;
    logic signed [Y_W-1:0] r_s4_ysimple;
    t_ysrc                 r_s4_ysrc;
    logic                  r_s4_last;

    always_comb begin
        // Rounded quotient by 3*2^23: drop 23 bits first, the divide by 3 follows.
        n_sqr  = (SQ_W+1)'(r_s3_sq) + (SQ_W+1)'(3 * (64'd1 << (WFRAC - 1)));
        n_u    = n_sqr[SQ_W:WFRAC];
        n_e    = r_s3_e0 - r_s3_ep[EP_W-1:ETF];
        n_emag = ONE_T - {1'b0, n_e} + (TAB_W+1)'(128);
        n_mag  = r_s3_sat ? Y_W'(ONE_W_L) : Y_W'(n_emag[TAB_W:8]);
        n_yexp = r_s3_neg ? -signed'(n_mag) : signed'(n_mag);
    end

    always_ff @(posedge i_clk) begin
        if (en4 && r_v3) begin
            r_s4_qp      <= QP_W'(n_u) * QP_W'(RECIP3);
            r_s4_yexp    <= n_yexp;
            r_s4_ysimple <= r_s3_ysimple;
            r_s4_ysrc    <= r_s3_ysrc;
            r_s4_last    <= r_s3_last;
        end
    end

    // ---------------- Stage 5: final select, round and saturate ----------------
    logic [QP_W-RECIP3_SH-1:0] n_q;
    logic signed [Y_W-1:0]     n_qs;
    logic signed [Y_W-1:0]     n_y;
    logic signed [R_W-1:0]     n_r;
    logic signed [SAMPLE_WIDTH-1:0] n_out;

    logic signed [SAMPLE_WIDTH-1:0] r_s5_out;
    logic                           r_s5_last;

    always_comb begin
        n_q  = r_s4_qp[QP_W-1:RECIP3_SH];
        n_qs = signed'(Y_W'(n_q));
        unique case (r_s4_ysrc)
            YSRC_POLY_POS: n_y = Y_ONE - n_qs;
            YSRC_POLY_NEG: n_y = n_qs - Y_ONE;
            YSRC_EXP:      n_y = r_s4_yexp;
            default:       n_y = r_s4_ysimple;
        endcase
        n_r = ((R_W'(n_y) + R_W'(OUT_RND)) >>> OUT_SH) <<< OUT_LSH;
        if (n_r > OMAX) begin
            n_out = SAMPLE_WIDTH'(OMAX);
        end else if (n_r < OMIN) begin
            n_out = SAMPLE_WIDTH'(OMIN);
        end else begin
            n_out = n_r[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5 && r_v4) begin
            r_s5_out  <= n_out;
            r_s5_last <= r_s4_last;
        end
    end

    assign o_smp.valid      = r_v5;
    assign o_smp.left       = r_s5_out;
    assign o_smp.right      = r_s5_out;
    assign o_smp.frame_last = r_s5_last;

endmodule
